// ===== rtl/core/nmeagga_pkg.sv =====
// ----------------------------------------------------------------------------
// nmeagga_pkg
// Shared types, character codes and field helpers for the GGA sentence parser.
// ----------------------------------------------------------------------------
package nmeagga_pkg;

   localparam int unsigned ACC_W   = 30;
   localparam int unsigned RSP_W   = 152;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_UP_F   = 8'h46;
   localparam logic [7:0] CHAR_UP_G   = 8'h47;
   localparam logic [7:0] CHAR_UP_P   = 8'h50;
   localparam logic [7:0] CHAR_LO_A   = 8'h61;
   localparam logic [7:0] CHAR_LO_F   = 8'h66;

   localparam logic [2:0] HDR_LEN     = 3'd7;
   localparam logic [2:0] SCALE_MAX   = 3'd4;

   localparam logic [3:0] FIELD_MAX     = 4'd15;
   localparam logic [3:0] FIELD_LAT     = 4'd2;
   localparam logic [3:0] FIELD_LAT_HEM = 4'd3;
   localparam logic [3:0] FIELD_LON     = 4'd4;
   localparam logic [3:0] FIELD_LON_HEM = 4'd5;
   localparam logic [3:0] FIELD_FIX     = 4'd6;
   localparam logic [3:0] FIELD_SATS    = 4'd7;
   localparam logic [3:0] FIELD_HDOP    = 4'd8;
   localparam logic [3:0] FIELD_ALT     = 4'd9;

   localparam logic [29:0] CAP_LATLON = 30'd999999999;
   localparam logic [29:0] CAP_FIX    = 30'd15;
   localparam logic [29:0] CAP_SATS   = 30'd99;
   localparam logic [29:0] CAP_HDOP   = 30'd9999999;
   localparam logic [29:0] CAP_ALT    = 30'd99999999;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_NUM,
      KIND_HEM
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [2:0]  scale;
      logic [29:0] cap;
   } finfo_type;

   typedef struct packed {
      logic [29:0]        lat;
      logic [29:0]        lon;
      logic [7:0]         lat_hem;
      logic [7:0]         lon_hem;
      logic [3:0]         fix;
      logic [6:0]         sats;
      logic [23:0]        hdop;
      logic signed [27:0] alt;
   } saved_type;

   typedef struct packed {
      logic [7:0]  xor_sum;
      logic [7:0]  rcv_sum;
      logic        in_cks;
      logic        hdr_ok;
      logic [3:0]  field;
      logic [29:0] acc;
      logic [2:0]  frac;
      logic        neg;
      saved_type   saved;
   } snap_type;

   function automatic finfo_type field_info(input logic [3:0] fnum);
      finfo_type fi;
      fi = '{kind: KIND_NONE, scale: 3'd0, cap: 30'd0};
      unique case (fnum)
         FIELD_LAT, FIELD_LON: fi = '{kind: KIND_NUM, scale: 3'd4, cap: CAP_LATLON};
         FIELD_LAT_HEM, FIELD_LON_HEM: fi.kind = KIND_HEM;
         FIELD_FIX:  fi = '{kind: KIND_NUM, scale: 3'd0, cap: CAP_FIX};
         FIELD_SATS: fi = '{kind: KIND_NUM, scale: 3'd0, cap: CAP_SATS};
         FIELD_HDOP: fi = '{kind: KIND_NUM, scale: 3'd2, cap: CAP_HDOP};
         FIELD_ALT:  fi = '{kind: KIND_NUM, scale: 3'd2, cap: CAP_ALT};
         default:    fi.kind = KIND_NONE;
      endcase
      return fi;
   endfunction

   function automatic logic [7:0] hdr_char(input logic [2:0] pos);
      logic [7:0] c;
      unique case (pos)
         3'd0:    c = CHAR_DOLLAR;
         3'd1:    c = CHAR_UP_G;
         3'd2:    c = CHAR_UP_P;
         3'd3:    c = CHAR_UP_G;
         3'd4:    c = CHAR_UP_G;
         3'd5:    c = CHAR_UP_A;
         3'd6:    c = CHAR_COMMA;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [13:0] pow10(input logic [2:0] k);
      logic [13:0] p;
      unique case (k)
         3'd0:    p = 14'd1;
         3'd1:    p = 14'd10;
         3'd2:    p = 14'd100;
         3'd3:    p = 14'd1000;
         default: p = 14'd10000;
      endcase
      return p;
   endfunction

   // pad missing fraction digits with one multiply, saturating at the cap
   function automatic logic [29:0] sat_scale(input logic [29:0] acc, input logic [2:0] frac,
                                             input logic [2:0] scale, input logic [29:0] cap);
      logic [2:0]  k;
      logic [43:0] prod;
      k    = (frac < scale) ? (scale - frac) : 3'd0;
      prod = {14'd0, acc} * {30'd0, pow10(k)};
      return (prod > {14'd0, cap}) ? cap : prod[29:0];
   endfunction

   function automatic saved_type close_field(input saved_type s, input logic [3:0] fnum,
                                             input logic [29:0] acc, input logic [2:0] frac,
                                             input logic neg);
      finfo_type   fi;
      logic [29:0] v;
      logic [29:0] nv;
      saved_type   r;
      fi = field_info(fnum);
      r  = s;
      v  = sat_scale(acc, frac, fi.scale, fi.cap);
      nv = 30'd0 - v;
      case (fnum)
         FIELD_LAT:     r.lat     = neg ? 30'd0 : v;
         FIELD_LON:     r.lon     = neg ? 30'd0 : v;
         FIELD_LAT_HEM: r.lat_hem = acc[7:0];
         FIELD_LON_HEM: r.lon_hem = acc[7:0];
         FIELD_FIX:     r.fix     = neg ? 4'd0 : v[3:0];
         FIELD_SATS:    r.sats    = neg ? 7'd0 : v[6:0];
         FIELD_HDOP:    r.hdop    = neg ? 24'd0 : v[23:0];
         FIELD_ALT:     r.alt     = neg ? nv[27:0] : v[27:0];
         default:       r         = s;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/nmeagga_track.sv =====
// ----------------------------------------------------------------------------
// nmeagga_track
// Per-byte sentence state: header match, running xor, checksum digits and
// field values; hands a snapshot of the state on at the final byte.
// ----------------------------------------------------------------------------
module nmeagga_track (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  logic [7:0]          item_byte,
   input  logic                item_last,
   output logic                item_take,
   output logic                snap_valid,
   output nmeagga_pkg::snap_type snap,
   input  logic                snap_ready
);

   logic [3:0]  field_ff,  field_in;
   logic [7:0]  xor_ff,    xor_in;
   logic [2:0]  pos_ff,    pos_in;
   logic        hmatch_ff, hmatch_in;
   logic        in_cks_ff, in_cks_in;
   logic [7:0]  rcv_ff,    rcv_in;
   logic [29:0] acc_ff,    acc_in;
   logic [2:0]  fd_ff,     fd_in;
   logic        point_ff,  point_in;
   logic        neg_ff,    neg_in;
   nmeagga_pkg::saved_type saved_ff, saved_in;
   logic                   snap_valid_ff;
   nmeagga_pkg::snap_type  snap_ff, snap_in;

   nmeagga_pkg::finfo_type finfo;
   nmeagga_pkg::saved_type closed;
   logic        first;
   logic        is_digit;
   logic [3:0]  digit;
   logic [3:0]  nib;
   logic [33:0] step;
   logic [29:0] step_sat;

   assign item_take  = item_valid && (!item_last || !snap_valid_ff || snap_ready);
   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

   always_comb begin
      first    = (pos_ff == 3'd0);
      finfo    = nmeagga_pkg::field_info(field_ff);
      closed   = nmeagga_pkg::close_field(saved_ff, field_ff, acc_ff, fd_ff, neg_ff);
      is_digit = (item_byte >= nmeagga_pkg::CHAR_ZERO) && (item_byte <= nmeagga_pkg::CHAR_NINE);
      digit    = item_byte[3:0];
      step     = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {30'd0, digit};
      step_sat = (step > {4'd0, finfo.cap}) ? finfo.cap : step[29:0];
      if (is_digit) begin
         nib = item_byte[3:0];
      end else if (((item_byte >= nmeagga_pkg::CHAR_UP_A) &&
                    (item_byte <= nmeagga_pkg::CHAR_UP_F)) ||
                   ((item_byte >= nmeagga_pkg::CHAR_LO_A) &&
                    (item_byte <= nmeagga_pkg::CHAR_LO_F))) begin
         nib = item_byte[3:0] + 4'd9;
      end else begin
         nib = 4'd0;
      end

      field_in  = field_ff;
      xor_in    = xor_ff;
      pos_in    = pos_ff;
      hmatch_in = hmatch_ff;
      in_cks_in = in_cks_ff;
      rcv_in    = rcv_ff;
      acc_in    = acc_ff;
      fd_in     = fd_ff;
      point_in  = point_ff;
      neg_in    = neg_ff;
      saved_in  = saved_ff;

      if (item_take) begin
         if (pos_ff < nmeagga_pkg::HDR_LEN) begin
            if (item_byte != nmeagga_pkg::hdr_char(pos_ff)) begin
               hmatch_in = 1'b0;
            end
            pos_in = pos_ff + 3'd1;
         end
         if (!first) begin
            if (in_cks_ff) begin
               rcv_in = {rcv_ff[3:0], nib};
            end else if (item_byte == nmeagga_pkg::CHAR_STAR) begin
               saved_in  = closed;
               acc_in    = 30'd0;
               fd_in     = 3'd0;
               point_in  = 1'b0;
               neg_in    = 1'b0;
               in_cks_in = 1'b1;
            end else begin
               xor_in = xor_ff ^ item_byte;
               if (item_byte == nmeagga_pkg::CHAR_COMMA) begin
                  saved_in = closed;
                  acc_in   = 30'd0;
                  fd_in    = 3'd0;
                  point_in = 1'b0;
                  neg_in   = 1'b0;
                  if (field_ff != nmeagga_pkg::FIELD_MAX) begin
                     field_in = field_ff + 4'd1;
                  end
               end else if (finfo.kind == nmeagga_pkg::KIND_HEM) begin
                  // bit 8 marks that the first character is held
                  if (!acc_ff[8]) begin
                     acc_in = {21'd0, 1'b1, item_byte};
                  end
               end else if (finfo.kind == nmeagga_pkg::KIND_NUM) begin
                  if (is_digit) begin
                     if (!point_ff) begin
                        acc_in = step_sat;
                     end else if (fd_ff < finfo.scale) begin
                        acc_in = step_sat;
                        fd_in  = fd_ff + 3'd1;
                     end
                  end else if (item_byte == nmeagga_pkg::CHAR_DOT) begin
                     point_in = 1'b1;
                  end else if ((item_byte == nmeagga_pkg::CHAR_MINUS) &&
                               (acc_ff == 30'd0) && !point_ff) begin
                     neg_in = 1'b1;
                  end
               end
            end
         end
      end

      snap_in.xor_sum = xor_in;
      snap_in.rcv_sum = rcv_in;
      snap_in.in_cks  = in_cks_in;
      snap_in.hdr_ok  = hmatch_in && (pos_in == nmeagga_pkg::HDR_LEN);
      snap_in.field   = field_in;
      snap_in.acc     = acc_in;
      snap_in.frac    = fd_in;
      snap_in.neg     = neg_in;
      snap_in.saved   = saved_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (item_take && item_last)) begin
         field_ff  <= 4'd0;
         xor_ff    <= 8'd0;
         pos_ff    <= 3'd0;
         hmatch_ff <= 1'b1;
         in_cks_ff <= 1'b0;
         rcv_ff    <= 8'd0;
         acc_ff    <= 30'd0;
         fd_ff     <= 3'd0;
         point_ff  <= 1'b0;
         neg_ff    <= 1'b0;
         saved_ff  <= '0;
      end else begin
         field_ff  <= field_in;
         xor_ff    <= xor_in;
         pos_ff    <= pos_in;
         hmatch_ff <= hmatch_in;
         in_cks_ff <= in_cks_in;
         rcv_ff    <= rcv_in;
         acc_ff    <= acc_in;
         fd_ff     <= fd_in;
         point_ff  <= point_in;
         neg_ff    <= neg_in;
         saved_ff  <= saved_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else if (item_take && item_last) begin
         snap_valid_ff <= 1'b1;
      end else if (snap_ready) begin
         snap_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take && item_last) begin
         snap_ff <= snap_in;
      end
   end

`ifndef SYNTHESIS
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      item_take && item_last |=> (pos_ff == 3'd0) && (xor_ff == 8'd0) &&
                                 !in_cks_ff && (field_ff == 4'd0))
      else $error("sentence state not cleared after final byte");

   a_cks_not_first: assert property (@(posedge clock) disable iff (reset)
      in_cks_ff |-> (pos_ff != 3'd0))
      else $error("checksum mode entered on the first byte");

   a_frac_bound: assert property (@(posedge clock) disable iff (reset)
      fd_ff <= nmeagga_pkg::SCALE_MAX)
      else $error("fraction digit count beyond largest scale");

   a_last_waits: assert property (@(posedge clock) disable iff (reset)
      snap_valid_ff && !snap_ready && item_valid && item_last |-> !item_take)
      else $error("final byte taken while snapshot is still held");
`endif

endmodule

// ===== rtl/core/nmeagga_finish.sv =====
// ----------------------------------------------------------------------------
// nmeagga_finish
// Closes the open field of a finished sentence, checks the checksum and
// packs the result into the registered output stage.
// ----------------------------------------------------------------------------
module nmeagga_finish (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                snap_valid,
   input  nmeagga_pkg::snap_type               snap,
   output logic                                snap_ready,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [nmeagga_pkg::RSP_W-1:0]       rsp_data
);

   logic                            rsp_valid_ff;
   logic [nmeagga_pkg::RSP_W-1:0]   rsp_data_ff, rsp_data_in;
   nmeagga_pkg::saved_type          fin;
   logic                            cks_ok;

   assign snap_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      // without a checksum the last field is still open
      fin = snap.in_cks ? snap.saved :
            nmeagga_pkg::close_field(snap.saved, snap.field, snap.acc, snap.frac, snap.neg);
      cks_ok      = snap.in_cks && (snap.xor_sum == snap.rcv_sum);
      rsp_data_in = {3'b000, fin.alt, fin.hdop, fin.lon_hem, fin.lon, fin.lat_hem, fin.lat,
                     fin.sats, fin.fix, snap.xor_sum, snap.hdr_ok, cks_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (snap_ready) begin
         rsp_valid_ff <= snap_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_valid && snap_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== rtl/core/nmea_gga_sentence_parser_unit.sv =====
// ----------------------------------------------------------------------------
// nmea_gga_sentence_parser_unit
// GGA sentence parser: one character per transaction in, one decoded result
// per sentence out.
// ----------------------------------------------------------------------------
// req channel: one character per transaction, req_tlast on the final one
// (the second checksum digit). rsp channel: one transaction per sentence,
// carrying checksum and header status, the computed xor and the fixed-point
// position, fix, satellite, dilution and altitude values.
// throughput: one character per cycle while req_tready is high, since each
// character only updates a small set of registers.
// a result passes the input register, the snapshot register and, after the
// closing logic, the output register before rsp_tvalid rises.
// characters that do not end a sentence produce no result.
// reset clears all sentence state and the input, snapshot and output valids.
// when the receiver stalls, the held result waits in the output register; a
// second finished sentence waits in the snapshot stage, and req_tready drops
// only once a further final character arrives with both stages full.
// ----------------------------------------------------------------------------
module nmea_gga_sentence_parser_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,  // byte_in
   input  logic          req_tlast,  // end_of_sentence
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // checksum_ok, header_ok, computed_checksum, fix_grade, satellite_count,
   // latitude_e4, latitude_hemisphere, longitude_e4, longitude_hemisphere,
   // dilution_e2, altitude_e2, zero fill
   output logic [151:0]  rsp_tdata
);

   logic                  in_valid_ff;
   logic [7:0]            in_byte_ff;
   logic                  in_last_ff;
   logic                  item_take;
   logic                  snap_valid;
   logic                  snap_ready;
   nmeagga_pkg::snap_type snap;

   assign req_tready = !in_valid_ff || item_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   nmeagga_track u_track (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_valid_ff),
      .item_byte  (in_byte_ff),
      .item_last  (in_last_ff),
      .item_take  (item_take),
      .snap_valid (snap_valid),
      .snap       (snap),
      .snap_ready (snap_ready)
   );

   nmeagga_finish u_finish (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap       (snap),
      .snap_ready (snap_ready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_data   (rsp_tdata)
   );

endmodule
